// ----- sv/lrup_pkg.sv -----
// Shared constants and widths for the LRU page replacement block.
package lrup_pkg;

    localparam int PAGE_W          = 16;
    localparam int FAULT_W         = 32;
    localparam int RES_W           = 5;
    localparam int CFG_W           = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

    localparam int DEF_MAX_FRAMES  = 16;
    localparam int DEF_PAGE_BITS   = 16;

    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

endpackage

// ----- sv/lrup_if.sv -----
// Request and response channel interfaces for the LRU page replacement block.
interface lrup_req_if;
    logic                       valid;
    logic                       ready;
    logic [lrup_pkg::PAGE_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lrup_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        was_hit;
    logic                        counted_fault;
    logic                        evicted_valid;
    logic [lrup_pkg::PAGE_W-1:0]  evicted_page;
    logic [lrup_pkg::FAULT_W-1:0] fault_total;
    logic [lrup_pkg::RES_W-1:0]   resident_total;

    modport source (output valid, output was_hit, output counted_fault,
                    output evicted_valid, output evicted_page, output fault_total,
                    output resident_total, input ready);
    modport sink   (input valid, input was_hit, input counted_fault,
                    input evicted_valid, input evicted_page, input fault_total,
                    input resident_total, output ready);
endinterface

// ----- sv/lrup_front.sv -----
// Front stage: accepts page references, masks them to the page width and registers them.
module lrup_front #(
    parameter int PAGE_BITS = lrup_pkg::DEF_PAGE_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lrup_req_if.sink             req,
    output logic                 push_valid,
    output logic [PAGE_BITS-1:0] push_page,
    input  logic                 push_ready
);
    import lrup_pkg::*;

    logic                 hold_valid_reg;
    logic                 hold_valid_next;
    logic [PAGE_BITS-1:0] hold_page_reg;
    logic                 take;

    assign req.ready  = !hold_valid_reg || push_ready;
    assign take       = req.valid && req.ready;
    assign push_valid = hold_valid_reg;
    assign push_page  = hold_page_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // drop the page bits above the configured page width
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_page_reg <= PAGE_BITS'(req.page_number);
        end
    end

endmodule

// ----- sv/lrup_queue.sv -----
// Short FIFO between the front stage and the replacement engine.
module lrup_queue #(
    parameter int WIDTH = lrup_pkg::DEF_PAGE_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data,
    input  logic             pop_ready
);
    import lrup_pkg::*;

    logic [WIDTH-1:0]       mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + QUEUE_CNT_W'(1);
            2'b01:   count_next = count_reg - QUEUE_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/lrup_engine.sv -----
// Replacement engine: parallel tag match, recency rank update, eviction and result register.
module lrup_engine #(
    parameter int MAX_FRAMES = lrup_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = lrup_pkg::DEF_PAGE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lrup_pkg::CFG_W-1:0]   frames_in_use,
    input  logic                         pop_valid,
    input  logic [PAGE_BITS-1:0]         pop_page,
    output logic                         pop_ready,
    lrup_rsp_if.source                   rsp
);
    import lrup_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [PAGE_BITS-1:0]  page_reg [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] valid_reg;
    logic [MAX_FRAMES-1:0] valid_next;
    logic [IDX_W-1:0]      rank_reg  [MAX_FRAMES];
    logic [IDX_W-1:0]      rank_next [MAX_FRAMES];
    logic [CNT_W-1:0]      occ_reg;
    logic [CNT_W-1:0]      occ_next;
    logic [FAULT_W-1:0]    fault_reg;
    logic [FAULT_W-1:0]    fault_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic                  hit_reg;
    logic                  fault_out_reg;
    logic [PAGE_W-1:0]     ev_page_reg;
    logic [RES_W-1:0]      res_reg;

    logic [CNT_W-1:0]      limit;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] victim;
    logic [MAX_FRAMES-1:0] free_sel;
    logic [MAX_FRAMES-1:0] sel;
    logic [IDX_W-1:0]      hit_rank;
    logic [IDX_W-1:0]      last_rank;
    logic [IDX_W-1:0]      free_idx;
    logic [PAGE_BITS-1:0]  ev_page;
    logic                  hit;
    logic                  fill;
    logic                  fault;
    logic                  advance;

    assign pop_ready = !out_valid_reg || rsp.ready;
    assign advance   = pop_valid && pop_ready;

    // clamp the frame limit to 1..MAX_FRAMES
    always_comb
    begin
        priority if (frames_in_use == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (32'(frames_in_use) > 32'(MAX_FRAMES))
        begin
            limit = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            limit = CNT_W'(frames_in_use);
        end
    end

    // frames fill in index order and are never freed, so the next free frame is the count
    assign free_idx  = occ_reg[IDX_W-1:0];
    assign last_rank = IDX_W'(occ_reg - CNT_W'(1));

    always_comb
    begin
        hit_rank = '0;
        ev_page  = '0;
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            match[k]    = valid_reg[k] && (page_reg[k] == pop_page);
            victim[k]   = valid_reg[k] && (rank_reg[k] == last_rank);
            free_sel[k] = (IDX_W'(k) == free_idx);
            if (match[k])
            begin
                hit_rank = hit_rank | rank_reg[k];
            end
            if (victim[k])
            begin
                ev_page = ev_page | page_reg[k];
            end
        end
    end

    assign hit   = |match;
    assign fill  = !hit && (occ_reg < limit);
    assign fault = !hit && !fill;

    always_comb
    begin
        priority if (hit)
        begin
            sel = match;
        end
        else if (fill)
        begin
            sel = free_sel;
        end
        else
        begin
            sel = victim;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        fault_next = fault_reg;
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            rank_next[k] = rank_reg[k];
        end
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            for (int k = 0; k < MAX_FRAMES; k++)
            begin
                if (sel[k])
                begin
                    rank_next[k] = '0;
                end
                else if (valid_reg[k] && (!hit || (rank_reg[k] < hit_rank)))
                begin
                    rank_next[k] = rank_reg[k] + IDX_W'(1);
                end
            end
            if (fill)
            begin
                valid_next = valid_reg | free_sel;
                occ_next   = occ_reg + CNT_W'(1);
            end
            if (fault && !(&fault_reg))
            begin
                fault_next = fault_reg + FAULT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            occ_reg       <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_FRAMES; k++)
            begin
                rank_reg[k] <= '0;
            end
        end
        else
        begin
            valid_reg     <= valid_next;
            occ_reg       <= occ_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < MAX_FRAMES; k++)
            begin
                rank_reg[k] <= rank_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < MAX_FRAMES; k++)
            begin
                if (sel[k] && !hit)
                begin
                    page_reg[k] <= pop_page;
                end
            end
            hit_reg       <= hit;
            fault_out_reg <= fault;
            ev_page_reg   <= fault ? PAGE_W'(ev_page) : '0;
            res_reg       <= RES_W'(occ_next);
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.was_hit        = hit_reg;
    assign rsp.counted_fault  = fault_out_reg;
    assign rsp.evicted_valid  = fault_out_reg;
    assign rsp.evicted_page   = ev_page_reg;
    assign rsp.fault_total    = fault_reg;
    assign rsp.resident_total = res_reg;

endmodule

// ----- sv/lru_page_replacement_top.sv -----
// Top level of the LRU page replacement block.
// Path: front register, then queue, then the engine, which registers each result.
// Throughput: one reference per cycle while rsp.ready; combinational match and rank update.
// Reset: clears frame valid marks, ranks, occupancy, fault count and sets the limit to 4.
module lru_page_replacement_top #(
    parameter int MAX_FRAMES = lrup_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = lrup_pkg::DEF_PAGE_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lrup_pkg::CFG_W-1:0] cfg_wdata,
    lrup_req_if.sink                   req,
    lrup_rsp_if.source                 rsp
);
    import lrup_pkg::*;

    logic [CFG_W-1:0]     frames_reg;
    logic [CFG_W-1:0]     frames_next;
    logic                 push_valid;
    logic [PAGE_BITS-1:0] push_page;
    logic                 push_ready;
    logic                 pop_valid;
    logic [PAGE_BITS-1:0] pop_page;
    logic                 pop_ready;

    assign frames_next = cfg_we ? cfg_wdata : frames_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= CFG_RESET;
        end
        else
        begin
            frames_reg <= frames_next;
        end
    end

    lrup_front #(
        .PAGE_BITS (PAGE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_page  (push_page),
        .push_ready (push_ready)
    );

    lrup_queue #(
        .WIDTH (PAGE_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_page),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_page),
        .pop_ready  (pop_ready)
    );

    lrup_engine #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .frames_in_use (frames_reg),
        .pop_valid     (pop_valid),
        .pop_page      (pop_page),
        .pop_ready     (pop_ready),
        .rsp           (rsp)
    );

endmodule
